// ===== hw/rtl/spvp_pkg.sv =====
package spvp_pkg;

    localparam int OFFSET_BITS = 17;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;
    localparam logic [15:0] FP_TYPE  = 16'h8028;
    localparam logic [31:0] FP_XOR   = 32'h5354554e;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;
    localparam int          HDR_LEN  = 20;

    localparam logic REC_ATTR    = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_GOOD   = 2'd0,
        ST_FORMAT = 2'd1,
        ST_FPRINT = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic        record_kind;
        logic [15:0] attr_type;
        logic [15:0] attr_length;
        logic [16:0] attr_value_offset;
        t_status     status;
        logic [1:0]  msg_class;
        logic [11:0] stun_method;
        logic [15:0] message_length;
        logic [31:0] txn_id_high;
        logic [63:0] txn_id_low;
        logic        is_last;
    } t_rec;

    // up to two records written into the output queue per processed byte
    typedef struct packed {
        logic [1:0] count;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

endpackage

// ===== hw/rtl/spvp_core.sv =====
module spvp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_go,
    input  spvp_pkg::t_in_beat i_beat,
    output spvp_pkg::t_push   o_push
);

    localparam int CB = spvp_pkg::OFFSET_BITS;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ spvp_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h21;
            2'd1:    v = 8'h12;
            2'd2:    v = 8'hA4;
            default: v = 8'h42;
        endcase
        return v;
    endfunction

    logic          r_check_fp;
    logic [CB-1:0] r_byte_count, n_byte_count;
    logic [31:0]   r_crc, n_crc;
    logic [15:0]   r_header_word, n_header_word;
    logic [15:0]   r_length_field, n_length_field;
    logic [31:0]   r_id_upper, n_id_upper;
    logic [63:0]   r_id_lower, n_id_lower;
    logic          r_header_bad, n_header_bad;
    logic [CB-1:0] r_attr_start, n_attr_start;
    logic [31:0]   r_attr_header, n_attr_header;
    logic [CB-1:0] r_attr_next, n_attr_next;
    logic          r_fp_found, n_fp_found;
    logic [31:0]   r_fp_expected, n_fp_expected;
    logic [31:0]   r_fp_received, n_fp_received;
    logic          r_fp_bad, n_fp_bad;

    logic [CB-1:0] pos, rel;
    logic [CB:0]   pos_inc, off_sum, len_end;
    logic [CB+1:0] nxt;
    logic [16:0]   padded;
    logic          attr_done, fmt_bad;
    logic [7:0]    b0, b1;
    spvp_pkg::t_rec    attr_rec, sum_rec;
    spvp_pkg::t_status st;

    always_comb begin
        n_byte_count   = r_byte_count;
        n_crc          = r_crc;
        n_header_word  = r_header_word;
        n_length_field = r_length_field;
        n_id_upper     = r_id_upper;
        n_id_lower     = r_id_lower;
        n_header_bad   = r_header_bad;
        n_attr_start   = r_attr_start;
        n_attr_header  = r_attr_header;
        n_attr_next    = r_attr_next;
        n_fp_found     = r_fp_found;
        n_fp_expected  = r_fp_expected;
        n_fp_received  = r_fp_received;
        n_fp_bad       = r_fp_bad;
        attr_rec       = '0;
        sum_rec        = '0;
        attr_done      = 1'b0;
        pos            = r_byte_count;
        rel            = pos - r_attr_start;
        pos_inc        = (CB+1)'(pos) + (CB+1)'(1);
        off_sum        = (CB+1)'(r_attr_start) + (CB+1)'(4);
        padded         = '0;
        nxt            = '0;

        if (pos < spvp_pkg::CNT_MAX) begin
            if (pos == '0 && (i_beat.data_byte & 8'hC0) != 8'h00) begin
                n_header_bad = 1'b1;
            end
            if (pos < CB'(2)) begin
                n_header_word = {r_header_word[7:0], i_beat.data_byte};
            end else if (pos < CB'(4)) begin
                n_length_field = {r_length_field[7:0], i_beat.data_byte};
            end else if (pos < CB'(8)) begin
                if (i_beat.data_byte != cookie_byte(pos[1:0])) begin
                    n_header_bad = 1'b1;
                end
            end else if (pos < CB'(12)) begin
                n_id_upper = {r_id_upper[23:0], i_beat.data_byte};
            end else if (pos < CB'(spvp_pkg::HDR_LEN)) begin
                n_id_lower = {r_id_lower[55:0], i_beat.data_byte};
            end

            if (pos >= r_attr_start) begin
                if (rel == '0 && !r_fp_found) begin
                    n_fp_expected = ~r_crc ^ spvp_pkg::FP_XOR;
                end
                if (rel < CB'(4)) begin
                    n_attr_header = {r_attr_header[23:0], i_beat.data_byte};
                    if (rel == CB'(3)) begin
                        // value padded to a multiple of four, length 65535 pads to 65536
                        padded = (17'(n_attr_header[15:0]) + 17'd3) & ~17'd3;
                        nxt = (CB+2)'(r_attr_start) + (CB+2)'(4) + (CB+2)'(padded);
                        n_attr_next = (nxt <= (CB+2)'(spvp_pkg::CNT_MAX)) ? nxt[CB-1:0] : '0;
                    end
                end else if (rel < CB'(8)) begin
                    n_fp_received = {r_fp_received[23:0], i_beat.data_byte};
                end
                if (rel >= CB'(3) && n_attr_next != '0 && pos_inc == (CB+1)'(n_attr_next)) begin
                    attr_done                  = 1'b1;
                    attr_rec.record_kind       = spvp_pkg::REC_ATTR;
                    attr_rec.attr_type         = n_attr_header[31:16];
                    attr_rec.attr_length       = n_attr_header[15:0];
                    attr_rec.attr_value_offset = off_sum[16:0];
                    if (n_attr_header[31:16] == spvp_pkg::FP_TYPE && !r_fp_found) begin
                        n_fp_found = 1'b1;
                        n_fp_bad   = (n_attr_header[15:0] != 16'd4) ||
                                     (n_fp_received != n_fp_expected);
                    end
                    n_attr_start = n_attr_next;
                    n_attr_next  = '0;
                end
            end
            n_crc        = crc_byte(r_crc, i_beat.data_byte);
            n_byte_count = pos_inc[CB-1:0];
        end

        len_end = (CB+1)'(n_length_field) + (CB+1)'(spvp_pkg::HDR_LEN);
        fmt_bad = n_header_bad || n_byte_count < CB'(spvp_pkg::HDR_LEN) ||
                  n_length_field[1:0] != 2'b00 || len_end > (CB+1)'(n_byte_count);
        if (fmt_bad) begin
            st = spvp_pkg::ST_FORMAT;
        end else if (r_check_fp && (!n_fp_found || n_fp_bad)) begin
            st = spvp_pkg::ST_FPRINT;
        end else begin
            st = spvp_pkg::ST_GOOD;
        end
        b0 = n_header_word[15:8];
        b1 = n_header_word[7:0];
        sum_rec.record_kind = spvp_pkg::REC_SUMMARY;
        sum_rec.status      = st;
        sum_rec.is_last     = 1'b1;
        if (st == spvp_pkg::ST_GOOD) begin
            sum_rec.msg_class      = {b0[0], b1[4]};
            sum_rec.stun_method    = {b0[5:1], b1[7:5], b1[3:0]};
            sum_rec.message_length = n_length_field;
            sum_rec.txn_id_high    = n_id_upper;
            sum_rec.txn_id_low     = n_id_lower;
        end

        o_push = '0;
        if (i_go) begin
            if (i_beat.last_byte) begin
                if (attr_done) begin
                    o_push.count = 2'd2;
                    o_push.rec0  = attr_rec;
                    o_push.rec1  = sum_rec;
                end else begin
                    o_push.count = 2'd1;
                    o_push.rec0  = sum_rec;
                end
            end else if (attr_done) begin
                o_push.count = 2'd1;
                o_push.rec0  = attr_rec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_fp <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_check_fp <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_beat.last_byte)) begin
            r_byte_count   <= '0;
            r_crc          <= spvp_pkg::CRC_INIT;
            r_header_word  <= '0;
            r_length_field <= '0;
            r_id_upper     <= '0;
            r_id_lower     <= '0;
            r_header_bad   <= 1'b0;
            r_attr_start   <= CB'(spvp_pkg::HDR_LEN);
            r_attr_header  <= '0;
            r_attr_next    <= '0;
            r_fp_found     <= 1'b0;
            r_fp_expected  <= '0;
            r_fp_received  <= '0;
            r_fp_bad       <= 1'b0;
        end else if (i_go) begin
            r_byte_count   <= n_byte_count;
            r_crc          <= n_crc;
            r_header_word  <= n_header_word;
            r_length_field <= n_length_field;
            r_id_upper     <= n_id_upper;
            r_id_lower     <= n_id_lower;
            r_header_bad   <= n_header_bad;
            r_attr_start   <= n_attr_start;
            r_attr_header  <= n_attr_header;
            r_attr_next    <= n_attr_next;
            r_fp_found     <= n_fp_found;
            r_fp_expected  <= n_fp_expected;
            r_fp_received  <= n_fp_received;
            r_fp_bad       <= n_fp_bad;
        end
    end

`ifndef SYNTHESIS
    a_two_recs_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count == 2'd2 |-> (o_push.rec0.record_kind == spvp_pkg::REC_ATTR &&
                                  o_push.rec1.record_kind == spvp_pkg::REC_SUMMARY))
        else $error("two records must be attribute then summary");
    a_push_needs_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.count != 2'd0 |-> i_go)
        else $error("record produced without a processed beat");
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && i_beat.last_byte |=> (r_byte_count == '0 && !r_fp_found))
        else $error("packet state not cleared after last beat");
    a_walk_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_attr_next != '0 |-> r_attr_next > r_attr_start)
        else $error("attribute end not beyond its start");
`endif

endmodule

// ===== hw/rtl/spvp_fifo.sv =====
module spvp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spvp_pkg::t_push i_push,
    input  logic            i_stall,
    output logic            o_room,
    output logic            o_valid,
    output spvp_pkg::t_rec  o_rec
);

    localparam int AW = spvp_pkg::FIFO_AW;

    spvp_pkg::t_rec mem [spvp_pkg::FIFO_DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [AW:0]    r_count, n_count;
    logic           pop;

    assign o_valid = r_count != '0;
    assign o_rec   = mem[r_rd_ptr];
    // a processed beat may push two records
    assign o_room  = r_count <= (AW+1)'(spvp_pkg::FIFO_DEPTH - 2);
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_push.count);
        n_rd_ptr = r_rd_ptr + AW'(pop);
        n_count  = r_count + (AW+1)'(i_push.count) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            mem[r_wr_ptr] <= i_push.rec0;
        end
        if (i_push.count == 2'd2) begin
            mem[r_wr_ptr + AW'(1)] <= i_push.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != 2'd0 |-> o_room)
        else $error("record pushed without room");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(spvp_pkg::FIFO_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_ptr - r_rd_ptr == r_count[AW-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== hw/rtl/stun_packet_validate_parse.sv =====
// channel   dir  handshake            payload
// input     in   i_valid / o_stall    i_beat  (one buffer byte, last flag)
// output    out  o_valid / i_stall    o_rec   (attribute or summary record)
// config    in   i_cfg_wr_en          i_cfg_wr_data (fingerprint check enable)
//
// one byte per cycle while o_stall is low; a taken byte is held in an input register
// and its records pass through a four-entry record queue before they are offered
// a byte that completes an attribute and ends the packet gives two records, sent
// one per cycle while i_stall is low; the input stalls while that queue has fewer
// than two free entries. synchronous active-low reset, no clearing pass
module stun_packet_validate_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  spvp_pkg::t_in_beat i_beat,
    output logic               o_valid,
    input  logic               i_stall,
    output spvp_pkg::t_rec     o_rec,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data
);

    logic               r_in_vld;
    spvp_pkg::t_in_beat r_in;
    logic               room, go;
    spvp_pkg::t_push    push;

    assign go      = r_in_vld && room;
    assign o_stall = r_in_vld && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_beat;
        end
    end

    spvp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_go         (go),
        .i_beat       (r_in),
        .o_push       (push)
    );

    spvp_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_stall(i_stall),
        .o_room (room),
        .o_valid(o_valid),
        .o_rec  (o_rec)
    );

`ifndef SYNTHESIS
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_vld && !room))
        else $error("input stalled with a free stage");
    a_beat_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !go |=> (r_in_vld && $stable(r_in)))
        else $error("held input beat lost or changed");
    a_go_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && !i_valid |=> !r_in_vld)
        else $error("input stage not emptied after processing");
`endif

endmodule
